// ===== src/decimal_record_line_parser_defines.svh =====
// ----------------------------------------------------------------------------
// decimal record line parser assertion macros
// shared property wrappers, all clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef DECIMAL_RECORD_LINE_PARSER_DEFINES_SVH
`define DECIMAL_RECORD_LINE_PARSER_DEFINES_SVH

// condition implies consequence in the same cycle
`define DLP_ASSERT_SAME(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("dlp assertion failed");

// condition implies consequence in the next cycle
`define DLP_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("dlp assertion failed");

`endif

// ===== src/dlp_pkg.sv =====
// ----------------------------------------------------------------------------
// dlp_pkg
// shared types and character codes of the decimal record line parser
// ----------------------------------------------------------------------------
package dlp_pkg;

  localparam int VALUE_W  = 32;
  localparam int BYTE_W   = 8;
  localparam int NUM_HELD = 4;
  localparam int POS_W    = 3;

  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;

  localparam logic [POS_W-1:0] POS_FULL = 3'd4;

  typedef struct packed {
    logic [VALUE_W-1:0] first_value_q11;
    logic [VALUE_W-1:0] second_value_q11;
    logic [VALUE_W-1:0] third_value_q11;
    logic [VALUE_W-1:0] fourth_value;
    logic [VALUE_W-1:0] fifth_value;
  } record_t;

  typedef struct packed {
    logic               valid;
    logic [BYTE_W-1:0]  char_code;
  } byte_req_t;

endpackage

// ===== src/dlp_in_stage.sv =====
// ----------------------------------------------------------------------------
// dlp_in_stage
// input register for one text byte request
// ----------------------------------------------------------------------------
module dlp_in_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [dlp_pkg::BYTE_W-1:0] s_tdata,   // char_code [7:0]
  input  logic                       fire,
  output dlp_pkg::byte_req_t         req
);

  logic                       in_valid;
  logic [dlp_pkg::BYTE_W-1:0] in_byte;
  logic                       take;

  assign s_tready = !in_valid || fire;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_byte <= s_tdata;
    end
  end

  assign req.valid     = in_valid;
  assign req.char_code = in_byte;

endmodule

// ===== src/dlp_field_core.sv =====
// ----------------------------------------------------------------------------
// dlp_field_core
// per-byte field accumulation, line state and record assembly
// ----------------------------------------------------------------------------
`include "decimal_record_line_parser_defines.svh"

module dlp_field_core #(
  parameter int MAX_LINE = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic [dlp_pkg::BYTE_W-1:0] char_code,
  output logic                       closing,
  output logic                       emit,
  output dlp_pkg::record_t           record
);

  localparam int CNT_W = $clog2(MAX_LINE + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_LINE - 1);

  logic [dlp_pkg::VALUE_W-1:0] acc, acc_next, acc_upd;
  logic                        neg, neg_next, neg_upd;
  logic [dlp_pkg::POS_W-1:0]   pos, pos_next, pos_upd;
  logic [dlp_pkg::VALUE_W-1:0] held      [dlp_pkg::NUM_HELD];
  logic [dlp_pkg::VALUE_W-1:0] held_next [dlp_pkg::NUM_HELD];
  logic [dlp_pkg::VALUE_W-1:0] held_upd  [dlp_pkg::NUM_HELD];
  logic [CNT_W-1:0]            count, count_next;
  logic                        skipping, skipping_next;

  logic                        is_sep, is_eol, is_space, is_minus;
  logic [dlp_pkg::VALUE_W-1:0] cur_signed, upd_signed, digit;

  assign is_eol   = (char_code == dlp_pkg::CH_CR) || (char_code == dlp_pkg::CH_LF);
  assign is_space = (char_code == dlp_pkg::CH_SPACE);
  assign is_minus = (char_code == dlp_pkg::CH_MINUS);
  assign is_sep   = is_eol || is_space;

  // the presented byte would close the line if it were processed
  assign closing = !(skipping && is_sep) && (is_eol || (count == CNT_LAST));

  assign digit      = dlp_pkg::VALUE_W'(char_code) - dlp_pkg::VALUE_W'(dlp_pkg::CH_ZERO);
  assign cur_signed = neg ? (- acc) : acc;

  // state after this byte, before any line reset
  always_comb begin
    acc_upd = acc;
    neg_upd = neg;
    pos_upd = pos;
    for (int i = 0; i < dlp_pkg::NUM_HELD; i++) begin
      held_upd[i] = held[i];
    end
    if (is_eol) begin
      // line ends with current state
    end else if (is_space) begin
      if (pos < dlp_pkg::POS_FULL) begin
        held_upd[pos[1:0]] = cur_signed;
        pos_upd            = pos + 1'b1;
      end
      acc_upd = '0;
      neg_upd = 1'b0;
    end else if (is_minus) begin
      neg_upd = 1'b1;
    end else begin
      acc_upd = (acc << 3) + (acc << 1) + digit;
    end
  end

  assign upd_signed = neg_upd ? (- acc_upd) : acc_upd;

  always_comb begin
    emit          = 1'b0;
    acc_next      = acc;
    neg_next      = neg;
    pos_next      = pos;
    count_next    = count;
    skipping_next = skipping;
    for (int i = 0; i < dlp_pkg::NUM_HELD; i++) begin
      held_next[i] = held[i];
    end
    if (fire && !(skipping && is_sep)) begin
      skipping_next = 1'b0;
      if (is_eol || (count == CNT_LAST)) begin
        // record goes out, line state starts over
        emit          = 1'b1;
        skipping_next = 1'b1;
        acc_next      = '0;
        neg_next      = 1'b0;
        pos_next      = '0;
        count_next    = '0;
        for (int i = 0; i < dlp_pkg::NUM_HELD; i++) begin
          held_next[i] = '0;
        end
      end else begin
        acc_next   = acc_upd;
        neg_next   = neg_upd;
        pos_next   = pos_upd;
        count_next = count + 1'b1;
        for (int i = 0; i < dlp_pkg::NUM_HELD; i++) begin
          held_next[i] = held_upd[i];
        end
      end
    end
  end

  assign record.first_value_q11  = held_upd[0];
  assign record.second_value_q11 = held_upd[1];
  assign record.third_value_q11  = held_upd[2];
  assign record.fourth_value     = held_upd[3];
  assign record.fifth_value      = upd_signed;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      neg      <= 1'b0;
      pos      <= '0;
      count    <= '0;
      skipping <= 1'b0;
      for (int i = 0; i < dlp_pkg::NUM_HELD; i++) begin
        held[i] <= '0;
      end
    end else begin
      acc      <= acc_next;
      neg      <= neg_next;
      pos      <= pos_next;
      count    <= count_next;
      skipping <= skipping_next;
      for (int i = 0; i < dlp_pkg::NUM_HELD; i++) begin
        held[i] <= held_next[i];
      end
    end
  end

  `DLP_ASSERT_SAME(a_pos_bounded, 1'b1, pos <= dlp_pkg::POS_FULL)
  `DLP_ASSERT_SAME(a_skip_clean_line, skipping, (count == '0) && (pos == '0) && (acc == '0))
  `DLP_ASSERT_SAME(a_emit_on_close, emit, closing)

endmodule

// ===== src/dlp_out_stage.sv =====
// ----------------------------------------------------------------------------
// dlp_out_stage
// result register holding one record until the sink takes it
// ----------------------------------------------------------------------------
module dlp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dlp_pkg::record_t record,
  input  logic             m_tready,
  output logic             m_tvalid,
  output dlp_pkg::record_t held_record
);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_record <= record;
    end
  end

endmodule

// ===== src/decimal_record_line_parser.sv =====
// ----------------------------------------------------------------------------
// decimal_record_line_parser
// parses space-separated signed decimal text into five-field records
// ----------------------------------------------------------------------------
// Takes one ASCII byte per request and builds a record of five signed 32-bit
// fields, one record per line. A minus anywhere in a field negates it; every
// other non-separator byte folds in as acc*10 + (byte-48) with 32-bit wrap.
// A line ends on CR or LF, or after MAX_LINE bytes, and the run of space, CR
// and LF that follows is skipped. Fields past the fourth are dropped; the
// number ending the line is always the fifth field, and fields the line does
// not reach read zero. The first three fields are Q11 codes, passed through
// bit for bit. Throughput is one byte per clock unless a line-closing byte
// waits on a full result register: the byte sits in an input register, and
// one shallow update step (shift-add by ten, field select) feeds the result
// register that holds the record. The input keeps taking bytes while a record
// waits, until a second record would be needed before the first is taken.
// ----------------------------------------------------------------------------
`include "decimal_record_line_parser_defines.svh"

module decimal_record_line_parser #(
  parameter int MAX_LINE = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // char_code [7:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  // first_value_q11 [31:0], second_value_q11 [63:32], third_value_q11 [95:64],
  // fourth_value [127:96], fifth_value [159:128]
  output logic [159:0] m_tdata
);

  dlp_pkg::byte_req_t req;
  dlp_pkg::record_t   record;
  dlp_pkg::record_t   held_record;
  logic               fire;
  logic               closing;
  logic               emit;

  // the byte in the input register is processed unless it closes a line
  // while the result register is still full and not being emptied
  assign fire = req.valid && (!closing || !m_tvalid || m_tready);

  dlp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .fire     (fire),
    .req      (req)
  );

  dlp_field_core #(
    .MAX_LINE (MAX_LINE)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .char_code (req.char_code),
    .closing   (closing),
    .emit      (emit),
    .record    (record)
  );

  dlp_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (emit),
    .record      (record),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .held_record (held_record)
  );

  // first field in the lowest bits
  assign m_tdata = {held_record.fifth_value,
                    held_record.fourth_value,
                    held_record.third_value_q11,
                    held_record.second_value_q11,
                    held_record.first_value_q11};

  // a stalled record blocks only a byte that would close the next line
  `DLP_ASSERT_SAME(a_stall_blocks_close, m_tvalid && !m_tready && closing, !fire)
  // a record is only produced by a processed byte
  `DLP_ASSERT_SAME(a_emit_needs_fire, emit, fire)
  // a processed byte with no new one arriving leaves the input register empty
  `DLP_ASSERT_NEXT(a_input_drains, fire && !s_tvalid, !req.valid)

endmodule

// ===== dv/decimal_record_line_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_record_line_parser_tb
// self-checking bench for the decimal record line parser
// ----------------------------------------------------------------------------
// Drives text bytes into the slave stream and checks every record on the
// master stream against a cycle-free model of the parser kept in the bench.
// A short table of hand-picked bytes comes first, with a few records typed
// in directly, then randomly built lines: mostly well-formed numbers with
// random signs, lengths and spacing, plus noise bytes, broken lines and a
// few lines that run past the length limit. Both stream sides pause at
// random, with calm stretches where neither side holds back.
// ----------------------------------------------------------------------------
module decimal_record_line_parser_tb;

  localparam int LINE_MAX     = 256;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 16;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;   // char_code [7:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // first_value_q11 [31:0], second_value_q11 [63:32], third_value_q11 [95:64],
  // fourth_value [127:96], fifth_value [159:128]
  logic [159:0] m_tdata;

  decimal_record_line_parser #(
    .MAX_LINE(LINE_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // parser model state, same reset values as the block
  // --------------------------------------------------------------------------
  logic [31:0] digit_acc = '0;
  bit          minus_seen = 1'b0;
  logic [2:0]  fields_closed = '0;
  logic [31:0] held_vals [4] = '{default: '0};
  int unsigned line_bytes_taken = 0;
  bit          line_skip = 1'b0;   // first line starts right after reset

  dlp_pkg::record_t pending_records [$];   // records still owed by the block
  int               mismatch_count = 0;
  int               cycle_count = 0;
  bit               calm = 1'b0;           // no pauses on either side while set

  // value of the open field with its sign applied
  function automatic logic [31:0] signed_acc();
    return minus_seen ? (32'd0 - digit_acc) : digit_acc;
  endfunction

  // builds the record for the current line and starts a fresh one
  function automatic void close_record(output dlp_pkg::record_t rec);
    rec.first_value_q11  = held_vals[0];
    rec.second_value_q11 = held_vals[1];
    rec.third_value_q11  = held_vals[2];
    rec.fourth_value     = held_vals[3];
    rec.fifth_value      = signed_acc();
    digit_acc        = '0;
    minus_seen       = 1'b0;
    fields_closed    = '0;
    held_vals        = '{default: '0};
    line_bytes_taken = 0;
    line_skip        = 1'b1;
  endfunction

  // advances the model by one byte, returns 1 when a record comes out
  function automatic bit parse_byte(input logic [7:0] c, output dlp_pkg::record_t rec);
    bit is_sep;
    is_sep = (c == dlp_pkg::CH_SPACE) || (c == dlp_pkg::CH_CR) || (c == dlp_pkg::CH_LF);
    rec = '0;
    if (line_skip) begin
      if (is_sep) return 1'b0;
      line_skip = 1'b0;
    end
    if (c == dlp_pkg::CH_CR || c == dlp_pkg::CH_LF) begin
      close_record(rec);
      return 1'b1;
    end
    if (c == dlp_pkg::CH_SPACE) begin
      // fields past the fourth are dropped, only the line's last number counts
      if (fields_closed < dlp_pkg::POS_FULL) begin
        held_vals[fields_closed[1:0]] = signed_acc();
        fields_closed = fields_closed + 3'd1;
      end
      digit_acc  = '0;
      minus_seen = 1'b0;
    end else if (c == dlp_pkg::CH_MINUS) begin
      minus_seen = 1'b1;
    end else begin
      // any other byte folds in like a digit, with 32-bit wrap
      digit_acc = digit_acc * 32'd10 + (32'(c) - 32'(dlp_pkg::CH_ZERO));
    end
    line_bytes_taken++;
    if (line_bytes_taken >= LINE_MAX) begin
      close_record(rec);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // pause length for either side: mostly none, some short, a few long
  function automatic int pick_pause();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %h, got %h", label, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // master side: random stalls, compare each record with the oldest one owed
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    dlp_pkg::record_t want_rec;
    int               pause;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_records.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected record %h", m_tdata);
        end else begin
          want_rec = pending_records.pop_front();
          check_field("first_value_q11", want_rec.first_value_q11, m_tdata[31:0]);
          check_field("second_value_q11", want_rec.second_value_q11, m_tdata[63:32]);
          check_field("third_value_q11", want_rec.third_value_q11, m_tdata[95:64]);
          check_field("fourth_value", want_rec.fourth_value, m_tdata[127:96]);
          check_field("fifth_value", want_rec.fifth_value, m_tdata[159:128]);
        end
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        pause = pick_pause();
        if (pause > 0) begin
          m_tready <= 1'b0;
          stall_left = pause - 1;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // slave side
  // --------------------------------------------------------------------------

  // one request: optional gap with tvalid low, then hold until accepted
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = pick_pause();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
  endtask

  typedef struct {
    logic [7:0]       code;
    bit               typed;   // record below is what this byte must produce
    dlp_pkg::record_t rec;
  } dir_row_t;

  dir_row_t    dir_rows [$];
  logic [7:0]  line_text [$];

  task automatic add_row(input logic [7:0] code, input bit typed = 1'b0,
                         input dlp_pkg::record_t rec = '0);
    dir_row_t row;
    row.code  = code;
    row.typed = typed;
    row.rec   = rec;
    dir_rows.push_back(row);
  endtask

  function automatic logic [7:0] any_digit();
    return dlp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // one number with random length, sign position and the odd noise byte
  task automatic append_number();
    int ndig;
    int minus_at;
    bit noisy;
    ndig  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 5);
    noisy = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 5))
      0, 1, 2: minus_at = -1;
      3, 4:    minus_at = 0;
      default: minus_at = $urandom_range(1, ndig);
    endcase
    for (int k = 0; k < ndig; k++) begin
      if (k == minus_at) line_text.push_back(dlp_pkg::CH_MINUS);
      if (noisy && $urandom_range(0, 2) == 0)
        line_text.push_back(8'($urandom_range(0, 255)));
      else
        line_text.push_back(any_digit());
    end
    if (minus_at == ndig) line_text.push_back(dlp_pkg::CH_MINUS);
    // a second minus now and then, still just a negation
    if ($urandom_range(0, 19) == 0) line_text.push_back(dlp_pkg::CH_MINUS);
  endtask

  task automatic build_line(input int line_no);
    int nf;
    int r;
    line_text.delete();
    r = $urandom_range(0, 99);
    if (line_no == 3 || r < 2) begin
      // runs past the length limit, the block must cut the record itself
      repeat (LINE_MAX + $urandom_range(0, 20)) begin
        case ($urandom_range(0, 19))
          0:       line_text.push_back(dlp_pkg::CH_MINUS);
          1:       line_text.push_back(dlp_pkg::CH_SPACE);
          2:       line_text.push_back(8'($urandom_range(128, 255)));
          default: line_text.push_back(any_digit());
        endcase
      end
    end else if (r < 12) begin
      // broken line: random bytes weighted toward the special codes
      repeat ($urandom_range(1, 15)) begin
        case ($urandom_range(0, 7))
          0:       line_text.push_back(dlp_pkg::CH_SPACE);
          1:       line_text.push_back(dlp_pkg::CH_MINUS);
          2:       line_text.push_back(dlp_pkg::CH_CR);
          3:       line_text.push_back(dlp_pkg::CH_LF);
          4:       line_text.push_back(any_digit());
          default: line_text.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      nf = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
      if ($urandom_range(0, 4) == 0) line_text.push_back(dlp_pkg::CH_SPACE);
      for (int f = 0; f < nf; f++) begin
        append_number();
        if (f < nf - 1) begin
          // doubled spaces close empty fields
          repeat (($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1)
            line_text.push_back(dlp_pkg::CH_SPACE);
        end
      end
      if ($urandom_range(0, 5) == 0) line_text.push_back(dlp_pkg::CH_SPACE);
      case ($urandom_range(0, 3))
        0: line_text.push_back(dlp_pkg::CH_CR);
        1: line_text.push_back(dlp_pkg::CH_LF);
        2: begin
          line_text.push_back(dlp_pkg::CH_CR);
          line_text.push_back(dlp_pkg::CH_LF);
        end
        default: begin
          line_text.push_back(dlp_pkg::CH_LF);
          line_text.push_back(dlp_pkg::CH_LF);
        end
      endcase
    end
  endtask

  initial begin
    dlp_pkg::record_t rec;
    bit               got;
    int               sent;
    int               line_no;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    // empty line right after reset gives an all-zero record
    add_row(dlp_pkg::CH_LF, 1'b1, '0);
    // separators after a record are skipped
    add_row(dlp_pkg::CH_SPACE);
    add_row(dlp_pkg::CH_CR);
    // six fields: the fifth is dropped, the line's last number is negated
    // by a trailing minus
    add_row(dlp_pkg::CH_MINUS);
    add_row("1");
    add_row(dlp_pkg::CH_SPACE);
    add_row("2");
    add_row(dlp_pkg::CH_SPACE);
    add_row("3");
    add_row(dlp_pkg::CH_SPACE);
    add_row("4");
    add_row(dlp_pkg::CH_SPACE);
    add_row("9");
    add_row(dlp_pkg::CH_SPACE);
    add_row("7");
    add_row(dlp_pkg::CH_MINUS);
    add_row(dlp_pkg::CH_CR, 1'b1,
            dlp_pkg::record_t'{32'hFFFF_FFFF, 32'd2, 32'd3, 32'd4, 32'hFFFF_FFF9});
    add_row(dlp_pkg::CH_LF);
    // non-digit bytes at both extremes still fold in
    add_row(8'hFF);
    add_row(8'h00);
    add_row(dlp_pkg::CH_LF);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].code);
      got = parse_byte(dir_rows[i].code, rec);
      if (got) pending_records.push_back(dir_rows[i].typed ? dir_rows[i].rec : rec);
    end

    // random part, line by line
    sent = 0;
    line_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 14) == 0) calm = !calm;
      build_line(line_no);
      foreach (line_text[i]) begin
        send_byte(line_text[i]);
        if (parse_byte(line_text[i], rec)) pending_records.push_back(rec);
        sent++;
      end
      line_no++;
    end

    s_tvalid <= 1'b0;
    calm = 1'b0;

    // drain: everything owed must arrive, then watch a little for extras
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_records.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== decimal_record_line_parser.f =====
+incdir+src
src/dlp_pkg.sv
src/dlp_in_stage.sv
src/dlp_field_core.sv
src/dlp_out_stage.sv
src/decimal_record_line_parser.sv
dv/decimal_record_line_parser_tb.sv
